@@ hw/rtl/cpsg_pkg.sv @@
// Package for the convex polygon span generator.
// Holds the request codes, default parameter values and fixed widths.
// No dependencies.
package cpsg_pkg;

  localparam int DEF_MAX_VERTICES    = 16;
  localparam int DEF_COORD_FRAC_BITS = 4;

  // Request kinds carried on in_tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SPAN = 1'b1;

  localparam int COORD_W = 16;  // vertex coordinate width
  localparam int EDGE_W  = 32;  // Q16.16 edge x and slope width
  localparam int SPAN_W  = 12;  // span output field width
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

endpackage

@@ hw/rtl/convex_polygon_span_generator_unit.sv @@
// Convex polygon span generator, top level.
// Depends on cpsg_pkg for request codes, widths and parameter defaults.

// Usage: send vertices of a convex counterclockwise polygon as load requests
// (in_tuser = 0, x in in_tdata[15:0], y in in_tdata[31:16], both signed with
// COORD_FRAC_BITS fraction bits) and mark the final one with in_tlast. Every
// span request (in_tuser = 1) then returns one result: the next scanline span
// from the lowest vertex upward, or a done result (out_tlast = 1, span fields
// zero) once no scanline remains or when no polygon is closed. A load returns
// nothing. Each time the walk has to enter a new edge, the block steps to the
// next vertex and reads the vertex pair, forms slope = dx/dy in the shared
// radix-2 restoring divider, and then saturates the slope, does the offset
// multiply and forms the final x. Edges that cross no scanline skip the divider
// and the multiply. The input is not ready while a request is being worked on,
// and a finished result that waits in the output register holds off a new
// request until the consumer takes it; the request can be taken in the same
// cycle as that result.
module convex_polygon_span_generator_unit #(
  parameter int MAX_VERTICES    = cpsg_pkg::DEF_MAX_VERTICES,
  parameter int COORD_FRAC_BITS = cpsg_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] vertex_x, [31:16] vertex_y
  input  logic [cpsg_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] opcode
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [11:0] span_row, [23:12] span_first_x, [35:24] span_end_x, [39:36] zero
  output logic [cpsg_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] span_nonempty
  output logic                            out_tuser,
  // polygon_done
  output logic                            out_tlast
);
  import cpsg_pkg::*;

  localparam int IW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam int FRAC  = COORD_FRAC_BITS;
  localparam int ROW_W = 17 - COORD_FRAC_BITS;
  localparam int PROD_W = 51;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_LWALK = 4'd2;
  localparam logic [3:0] S_RWALK = 4'd3;
  localparam logic [3:0] S_READ  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_SLOPE = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_XFIN  = 4'd8;

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  localparam logic signed [PROD_W-1:0] SAT_MAX = 51'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_MIN = -51'sd2147483648;

  // Scanline of a vertex y: ceil(y / 2^FRAC).
  function automatic logic signed [ROW_W-1:0] row_of(input logic signed [COORD_W-1:0] y);
    logic signed [COORD_W:0] s;
    s = 17'(y) + 17'((1 << FRAC) - 1);
    return ROW_W'(s >>> FRAC);
  endfunction

  function automatic logic signed [EDGE_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > SAT_MAX) return 32'sh7FFF_FFFF;
    if (v < SAT_MIN) return 32'sh8000_0000;
    return v[EDGE_W-1:0];
  endfunction

  // Pixel ceiling of a Q16.16 value.
  function automatic logic signed [16:0] ceil16(input logic signed [EDGE_W-1:0] x);
    logic signed [EDGE_W:0] s;
    s = 33'(x) + 33'sh0FFFF;
    return 17'(s >>> 16);
  endfunction

  // Vertex memory.
  logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];
  logic                      mem_we;
  logic [IW-1:0]             mem_waddr;
  logic                      rd_en;
  logic [IW-1:0]             rd_ta, rd_ba;
  logic signed [COORD_W-1:0] xt_r, yt_r, xb_r, yb_r;

  logic [3:0]                state_r, state_nxt;
  logic                      side_r, side_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [IW-1:0]             bottom_r, bottom_nxt;
  logic signed [COORD_W-1:0] lowest_r, lowest_nxt;
  logic [IW-1:0]             lidx_r, lidx_nxt, ridx_r, ridx_nxt;
  logic signed [ROW_W-1:0]   lend_r, lend_nxt, rend_r, rend_nxt, cur_r, cur_nxt;
  logic [CW-1:0]             edges_r, edges_nxt;
  logic signed [EDGE_W-1:0]  lx_r, lx_nxt, ls_r, ls_nxt, rx_r, rx_nxt, rs_r, rs_nxt;
  logic                      scan_r, scan_nxt, closed_r, closed_nxt;

  // Divider and multiplier datapath.
  logic [31:0]               dvd_r, dvd_nxt;
  logic [15:0]               rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [4:0]                cnt_r, cnt_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [EDGE_W-1:0]  slope_r, slope_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [SPAN_W-1:0]         o_row_r, o_row_nxt, o_fx_r, o_fx_nxt, o_ex_r, o_ex_nxt;
  logic                      o_ne_r, o_ne_nxt, o_done_r, o_done_nxt;

  logic                      accept;
  logic signed [COORD_W-1:0] in_x, in_y;
  logic [CW-1:0]             count_base;
  logic signed [ROW_W-1:0]   er;
  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W:0]          adx;
  logic [16:0]               trial;
  logic signed [17:0]        off;
  logic signed [PROD_W-1:0]  xsum;
  logic signed [16:0]        cl_l, cl_r;
  logic signed [EDGE_W-1:0]  xres;
  logic                      emit_span, emit_done;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign in_x      = in_tdata[15:0];
  assign in_y      = in_tdata[31:16];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, o_ex_r, o_fx_r, o_row_r};
  assign out_tuser  = o_ne_r;
  assign out_tlast  = o_done_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[mem_waddr] <= in_x;
      mem_y[mem_waddr] <= in_y;
    end
    if (rd_en) begin
      xt_r <= mem_x[rd_ta];
      yt_r <= mem_y[rd_ta];
      xb_r <= mem_x[rd_ba];
      yb_r <= mem_y[rd_ba];
    end
  end

  always_comb begin
    state_nxt  = state_r;    side_nxt   = side_r;
    count_nxt  = count_r;    bottom_nxt = bottom_r;   lowest_nxt = lowest_r;
    lidx_nxt   = lidx_r;     ridx_nxt   = ridx_r;
    lend_nxt   = lend_r;     rend_nxt   = rend_r;     cur_nxt    = cur_r;
    edges_nxt  = edges_r;
    lx_nxt     = lx_r;       ls_nxt     = ls_r;       rx_nxt     = rx_r;
    rs_nxt     = rs_r;
    scan_nxt   = scan_r;     closed_nxt = closed_r;
    dvd_nxt    = dvd_r;      rem_nxt    = rem_r;      dvs_nxt    = dvs_r;
    cnt_nxt    = cnt_r;      neg_nxt    = neg_r;
    slope_nxt  = slope_r;    prod_nxt   = prod_r;
    mem_we     = 1'b0;
    count_base = closed_r ? '0 : count_r;
    mem_waddr  = count_base[IW-1:0];
    rd_en      = 1'b0;
    rd_ta      = lidx_r;
    rd_ba      = lidx_r;
    emit_span  = 1'b0;
    emit_done  = 1'b0;
    er         = row_of(yt_r);
    dx         = 17'(xt_r) - 17'(xb_r);
    dy         = 17'(yt_r) - 17'(yb_r);
    adx        = dx[COORD_W] ? 17'(-dx) : 17'(dx);
    trial      = {rem_r, dvd_r[31]} - {1'b0, dvs_r};
    off        = (18'(cur_r) <<< FRAC) - 18'(yb_r);
    xsum       = (PROD_W'(xb_r) <<< (16 - FRAC)) + (prod_r >>> FRAC);
    xres       = sat32(xsum);
    cl_l       = ceil16(lx_r);
    cl_r       = ceil16(rx_r);

    case (state_r)
      S_IDLE: begin
        if (accept && in_tuser == OP_LOAD) begin
          if (closed_r) begin
            closed_nxt = 1'b0;
            scan_nxt   = 1'b0;
          end
          if (count_base < CW'(MAX_VERTICES)) begin
            mem_we = 1'b1;
            if (count_base == '0 || in_y < lowest_r) begin
              lowest_nxt = in_y;
              bottom_nxt = count_base[IW-1:0];
            end
            count_nxt = count_base + 1'b1;
          end else begin
            count_nxt = count_base;
          end
          if (in_tlast) begin
            closed_nxt = 1'b1;
            scan_nxt   = 1'b1;
            edges_nxt  = count_nxt;
            lidx_nxt   = bottom_nxt;
            ridx_nxt   = bottom_nxt;
            cur_nxt    = row_of(lowest_nxt);
            lend_nxt   = row_of(lowest_nxt);
            rend_nxt   = row_of(lowest_nxt);
          end
        end else if (accept) begin
          if (scan_r) state_nxt = S_CHECK;
          else        emit_done = 1'b1;
        end
      end
      S_CHECK: begin
        if (cur_r < lend_r && cur_r < rend_r) begin
          emit_span = 1'b1;
          cur_nxt   = cur_r + 1'b1;
          lx_nxt    = sat32(PROD_W'(lx_r) + PROD_W'(ls_r));
          rx_nxt    = sat32(PROD_W'(rx_r) + PROD_W'(rs_r));
          state_nxt = S_IDLE;
        end else if (edges_r == '0 || count_r == '0) begin
          scan_nxt  = 1'b0;
          emit_done = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_LWALK;
        end
      end
      S_LWALK: begin
        if (lend_r <= cur_r && edges_r != '0) begin
          edges_nxt = edges_r - 1'b1;
          lidx_nxt  = (lidx_r == '0) ? IW'(count_r - 1'b1) : lidx_r - 1'b1;
          rd_en     = 1'b1;
          rd_ta     = lidx_nxt;
          rd_ba     = lidx_r;
          side_nxt  = SIDE_LEFT;
          state_nxt = S_READ;
        end else begin
          state_nxt = S_RWALK;
        end
      end
      S_RWALK: begin
        if (rend_r <= cur_r && edges_r != '0) begin
          edges_nxt = edges_r - 1'b1;
          ridx_nxt  = (CW'(ridx_r) == count_r - 1'b1) ? '0 : ridx_r + 1'b1;
          rd_en     = 1'b1;
          rd_ta     = ridx_nxt;
          rd_ba     = ridx_r;
          side_nxt  = SIDE_RIGHT;
          state_nxt = S_READ;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_READ: begin
        if (side_r == SIDE_LEFT) lend_nxt = er;
        else                     rend_nxt = er;
        if (er > cur_r) begin
          if (dy > 0) begin
            neg_nxt   = dx[COORD_W];
            dvd_nxt   = {adx[15:0], 16'b0};
            dvs_nxt   = dy[15:0];
            rem_nxt   = '0;
            cnt_nxt   = 5'd31;
            state_nxt = S_DIV;
          end else begin
            slope_nxt = '0;
            state_nxt = S_MUL;
          end
        end else begin
          state_nxt = (side_r == SIDE_LEFT) ? S_LWALK : S_RWALK;
        end
      end
      S_DIV: begin
        // One quotient bit per cycle; the quotient shifts in behind the dividend.
        if (!trial[16]) rem_nxt = trial[15:0];
        else            rem_nxt = {rem_r[14:0], dvd_r[31]};
        dvd_nxt = {dvd_r[30:0], !trial[16]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_SLOPE;
      end
      S_SLOPE: begin
        if (!neg_r) slope_nxt = dvd_r[31] ? 32'sh7FFF_FFFF : $signed(dvd_r);
        else        slope_nxt = (dvd_r > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-dvd_r);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(slope_r) * PROD_W'(off);
        state_nxt = S_XFIN;
      end
      S_XFIN: begin
        if (side_r == SIDE_LEFT) begin
          lx_nxt    = xres;
          ls_nxt    = slope_r;
          state_nxt = S_LWALK;
        end else begin
          rx_nxt    = xres;
          rs_nxt    = slope_r;
          state_nxt = S_RWALK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: holds a result until the consumer takes it.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    o_row_nxt = o_row_r;  o_fx_nxt = o_fx_r;  o_ex_nxt = o_ex_r;
    o_ne_nxt  = o_ne_r;   o_done_nxt = o_done_r;
    if (emit_span) begin
      out_valid_nxt = 1'b1;
      o_row_nxt  = SPAN_W'(cur_r);
      o_fx_nxt   = cl_l[SPAN_W-1:0];
      o_ex_nxt   = cl_r[SPAN_W-1:0];
      o_ne_nxt   = cl_r > cl_l;
      o_done_nxt = 1'b0;
    end else if (emit_done) begin
      out_valid_nxt = 1'b1;
      o_row_nxt  = '0;
      o_fx_nxt   = '0;
      o_ex_nxt   = '0;
      o_ne_nxt   = 1'b0;
      o_done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      side_r      <= SIDE_LEFT;
      count_r     <= '0;
      bottom_r    <= '0;
      lowest_r    <= '0;
      lidx_r      <= '0;
      ridx_r      <= '0;
      lend_r      <= '0;
      rend_r      <= '0;
      cur_r       <= '0;
      edges_r     <= '0;
      lx_r        <= '0;
      ls_r        <= '0;
      rx_r        <= '0;
      rs_r        <= '0;
      scan_r      <= 1'b0;
      closed_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      side_r      <= side_nxt;
      count_r     <= count_nxt;
      bottom_r    <= bottom_nxt;
      lowest_r    <= lowest_nxt;
      lidx_r      <= lidx_nxt;
      ridx_r      <= ridx_nxt;
      lend_r      <= lend_nxt;
      rend_r      <= rend_nxt;
      cur_r       <= cur_nxt;
      edges_r     <= edges_nxt;
      lx_r        <= lx_nxt;
      ls_r        <= ls_nxt;
      rx_r        <= rx_nxt;
      rs_r        <= rs_nxt;
      scan_r      <= scan_nxt;
      closed_r    <= closed_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    neg_r   <= neg_nxt;
    slope_r <= slope_nxt;
    prod_r  <= prod_nxt;
    o_row_r <= o_row_nxt;
    o_fx_r  <= o_fx_nxt;
    o_ex_r  <= o_ex_nxt;
    o_ne_r  <= o_ne_nxt;
    o_done_r <= o_done_nxt;
  end

  // A new request is only taken by an idle sequencer.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE)
    else $error("input ready outside idle state");

  // The span check never finds a result still waiting in the output register.
  a_check_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> !out_valid_r)
    else $error("span produced over a pending result");

  // While a scan runs, the edge budget never exceeds the number of stored vertices.
  a_edges_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r |-> edges_r <= count_r)
    else $error("edge count above vertex count");

  // The divider always finishes into the slope saturation step.
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == '0) |=> state_r == S_SLOPE)
    else $error("divider exit lost");

endmodule

@@ tb/sv/convex_polygon_span_generator_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the convex polygon span generator.
// It depends on cpsg_pkg and on the convex_polygon_span_generator_unit RTL.

// Span predictor and result store. Each accepted request updates a private copy of
// the block's state. A span request queues the one result it must produce, and each
// result the block returns is checked against the oldest queued result.
class span_scoreboard;
  localparam int NV = cpsg_pkg::DEF_MAX_VERTICES;
  localparam int FB = cpsg_pkg::DEF_COORD_FRAC_BITS;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] first_x;
    logic [11:0] end_x;
    logic        nonempty;
    logic        done;
  } span_t;

  int    vx[NV];
  int    vy[NV];
  int    count, bottom, lowest_y, li, ri, lend, rend, row, edges;
  int    lx, ls, rx, rs;
  bit    active, closed;
  span_t spans_due[$];
  int    mismatches;

  function new();
    count = 0; bottom = 0; lowest_y = 0; li = 0; ri = 0;
    lend = 0; rend = 0; row = 0; edges = 0;
    lx = 0; ls = 0; rx = 0; rs = 0;
    active = 0; closed = 0; mismatches = 0;
  endfunction

  function int pending();
    return spans_due.size();
  endfunction

  function int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  // Arithmetic shift is floor division by a power of two.
  function longint ceil_shr(longint v, int s);
    return -((-v) >>> s);
  endfunction

  function void enter_edge(int b, int t, output int x, output int slope);
    longint dx, dy, off;
    int     s;
    dx = longint'(vx[t]) - vx[b];
    dy = longint'(vy[t]) - vy[b];
    s = (dy > 0) ? sat32((dx * 65536) / dy) : 0;
    off = longint'(row) * (64'sd1 << FB) - vy[b];
    slope = s;
    x = sat32(longint'(vx[b]) * (64'sd1 << (16 - FB)) + ((longint'(s) * off) >>> FB));
  endfunction

  function void note_request(logic op, logic [31:0] data, logic last);
    span_t  r;
    longint cl, cr;
    int     prev;
    if (op == cpsg_pkg::OP_LOAD) begin
      if (closed) begin
        closed = 0; active = 0; count = 0;
      end
      if (count < NV) begin
        vx[count] = int'($signed(data[15:0]));
        vy[count] = int'($signed(data[31:16]));
        if (count == 0 || vy[count] < lowest_y) begin
          lowest_y = vy[count];
          bottom = count;
        end
        count++;
      end
      if (last) begin
        row = (count > 0) ? int'(ceil_shr(vy[bottom], FB)) : 0;
        closed = 1; active = 1; edges = count;
        li = bottom; ri = bottom; lend = row; rend = row;
      end
      return;
    end
    r = '0;
    r.done = 1;
    for (int it = 0; it < NV + 3 && active; it++) begin
      if (row < lend && row < rend) begin
        cl = ceil_shr(lx, 16);
        cr = ceil_shr(rx, 16);
        r.row = row[11:0];
        r.first_x = cl[11:0];
        r.end_x = cr[11:0];
        r.nonempty = cr > cl;
        r.done = 0;
        row++;
        lx = sat32(longint'(lx) + ls);
        rx = sat32(longint'(rx) + rs);
        spans_due.push_back(r);
        return;
      end
      if (edges <= 0 || count <= 0) break;
      while (lend <= row && edges > 0) begin
        prev = li;
        edges--;
        li = (li + count - 1) % count;
        lend = int'(ceil_shr(vy[li], FB));
        if (lend > row) enter_edge(prev, li, lx, ls);
      end
      while (rend <= row && edges > 0) begin
        prev = ri;
        edges--;
        ri = (ri + 1) % count;
        rend = int'(ceil_shr(vy[ri], FB));
        if (rend > row) enter_edge(prev, ri, rx, rs);
      end
    end
    active = 0;
    spans_due.push_back(r);
  endfunction

  function void check_span(logic [39:0] data, logic nonempty, logic done);
    span_t want;
    if (spans_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result: tdata=%h tuser=%b tlast=%b",
                                     data, nonempty, done);
      return;
    end
    want = spans_due.pop_front();
    if (data !== {4'b0, want.end_x, want.first_x, want.row} ||
        nonempty !== want.nonempty || done !== want.done) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Span mismatch: want row=%h first=%h end=%h ne=%b done=%b, got tdata=%h ne=%b done=%b",
                 want.row, want.first_x, want.end_x, want.nonempty, want.done,
                 data, nonempty, done);
    end
  endfunction
endclass

module convex_polygon_span_generator_unit_tb;
  import cpsg_pkg::*;

  localparam int ITEM_TARGET  = 700;
  localparam int STALL_LIMIT  = 20000;  // cycles without any handshake
  localparam int DRAIN_CYCLES = 100;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  span_scoreboard sb;
  int  requests_sent;
  int  idle_cycles;
  bit  sender_calm;    // when set, the sender never inserts gaps
  bit  receiver_calm;  // when set, the receiver never stalls

  // Octagon directions used to build random convex counterclockwise polygons.
  int dir_x[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
  int dir_y[8] = '{0, 1, 1, 1, 0, -1, -1, -1};

  convex_polygon_span_generator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Both channels are sampled at the rising edge, where the values seen are the
  // ones from before the edge, so the handshake order within a step does not matter.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_request(in_tuser, in_tdata, in_tlast);
      requests_sent++;
    end
    if (rst_n && out_tvalid && out_tready) sb.check_span(out_tdata, out_tuser, out_tlast);
  end

  // The watchdog ends a hung run. Any accepted request or result restarts its count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver draws a stall for each result. Calm stretches give back-to-back
  // acceptance. A zero stall leaves tready high, so tready gets one assignment per step.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = receiver_calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Sends one request after a random gap and returns once the block takes it.
  // tvalid stays high between requests that have no gap between them.
  task automatic send_request(logic op, logic signed [15:0] x, logic signed [15:0] y,
                              logic last);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {y, x};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // A span request. The data and tlast carry random values, which the block ignores.
  task automatic ask_span();
    send_request(OP_SPAN, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic ask_spans(int n);
    for (int i = 0; i < n; i++) ask_span();
  endtask

  // Waits with the sender idle until every queued result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Builds a polygon from a subset of octagon directions around a random center,
  // with jitter on each vertex, and then asks for up to 40 of its scanlines.
  task automatic random_polygon();
    logic [7:0] mask;
    int cx, cy, r, n, rows, k;
    mask = 8'($urandom_range(0, 255));
    if ($countones(mask) < 3) mask |= 8'b0100_1001;
    n  = $countones(mask);
    r  = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 1200) : $urandom_range(4, 160);
    cx = $urandom_range(0, 60000) - 30000;
    cy = $urandom_range(0, 60000) - 30000;
    k  = 0;
    for (int d = 0; d < 8; d++) begin
      if (mask[d]) begin
        k++;
        send_request(OP_LOAD, 16'(cx + dir_x[d] * r + $urandom_range(0, 15) - 8),
                     16'(cy + dir_y[d] * r + $urandom_range(0, 15) - 8), k == n);
      end
    end
    rows = (2 * r) / 16 + 3;
    if (rows > 40) rows = 40;
    // Now and then the scan is cut short by a new polygon.
    if ($urandom_range(0, 4) == 0) rows = $urandom_range(0, rows);
    ask_spans(rows);
  endtask

  // Loads of unrelated random vertices, sometimes past the store depth, and requests
  // with all fields random. These cover every input bit and the non-convex walk.
  task automatic random_noise();
    int n;
    n = $urandom_range(1, 20);
    for (int i = 0; i < n; i++)
      send_request($urandom_range(0, 3) == 0, 16'($urandom), 16'($urandom),
                   (i == n - 1) || ($urandom_range(0, 15) == 0));
  endtask

  initial begin
    sb = new();
    requests_sent = 0;
    idle_cycles   = 0;
    sender_calm   = 0;
    receiver_calm = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_LOAD;
    in_tlast  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A span request before any polygon is closed answers with done.
    ask_span();
    // A polygon of a single vertex has no scanline.
    send_request(OP_LOAD, 16'sd0, 16'sd0, 1'b1);
    ask_spans(2);
    // Extreme coordinates: wide spans that wrap to 12 bits and saturating edge math.
    send_request(OP_LOAD, 16'sh8000, 16'sh8000, 1'b0);
    send_request(OP_LOAD, 16'sd32767, 16'sh8000, 1'b0);
    send_request(OP_LOAD, 16'sd0, 16'sd32767, 1'b1);
    ask_spans(3);
    // A load after a closed polygon discards it. This square has fractional corners.
    send_request(OP_LOAD, 16'sd17, 16'sd9, 1'b0);
    send_request(OP_LOAD, 16'sd83, 16'sd9, 1'b0);
    send_request(OP_LOAD, 16'sd83, 16'sd57, 1'b0);
    send_request(OP_LOAD, 16'sd17, 16'sd57, 1'b1);
    // This runs past the top, so the result is done and stays done.
    ask_spans(6);
    // Eighteen loads: the last two are not stored, but the final mark still closes.
    sender_calm = 1;
    for (int i = 0; i < 18; i++)
      send_request(OP_LOAD, 16'(i * 40), 16'((i % 5) * 24 - (i % 3) * 7), i == 17);
    sender_calm = 0;
    ask_spans(8);

    // The sender holds off until every queued result is back.
    drain();

    while (requests_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        sender_calm   = 1'($urandom_range(0, 1));
        receiver_calm = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 9) == 0) random_noise();
      else random_polygon();
      if ($urandom_range(0, 29) == 0) drain();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
